>>> hdl/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and control types of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CAPACITY  = 32;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  // common width for comparing the 6-bit request count with the fill count
  localparam int CMP_W     = (CNT_W > 6) ? CNT_W : 6;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_DELETE     = 3'd4;
  localparam logic [2:0] FUNC_FIRST_N    = 3'd5;
  localparam logic [2:0] FUNC_LAST_N     = 3'd6;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic       load;       // capture the input word
    logic       clear;      // empty the store
    logic       push;       // write key at front or back
    logic       pop;        // drop front or back entry
    logic       walk_init;  // set up a delete or listing walk
    logic       rd;         // read the store into the read register
    logic       del_step;   // compare read entry, compact if kept
    logic       step;       // advance walk index
    logic       emit;       // load the output register
    logic       emit_val;   // result carries the read entry
    logic       emit_last;  // final result of this word
    logic [1:0] emit_st;    // status code of the result
  } bdq_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       clr;
    logic       empty;
    logic       full;
    logic       cnt_zero;
    logic       walk_last;
    logic       out_free;
  } bdq_stat_t;

  // ring position of logical offset ofs from base; ofs < CAPACITY
  function automatic logic [IDX_W-1:0] bdq_slot(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/bdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer of the deque: decodes each word and steps the datapath.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire bdq_stat_t stat,
  output bdq_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_POP      = 3'd2;
  localparam logic [2:0] S_DEL_RD   = 3'd3;
  localparam logic [2:0] S_DEL_WR   = 3'd4;
  localparam logic [2:0] S_LST_RD   = 3'd5;
  localparam logic [2:0] S_LST_EMIT = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= STATUS_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_EMIT;
        st_nxt    = STATUS_OK;
        if (stat.clr) begin
          cmd.clear = 1'b1;
        end else begin
          case (stat.func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              if (stat.full) begin
                st_nxt = STATUS_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
              if (stat.empty) begin
                st_nxt = STATUS_EMPTY;
              end else begin
                cmd.rd    = 1'b1;
                state_nxt = S_POP;
              end
            end
            FUNC_DELETE: begin
              if (stat.empty) begin
                st_nxt = STATUS_EMPTY;
              end else begin
                cmd.walk_init = 1'b1;
                state_nxt     = S_DEL_RD;
              end
            end
            FUNC_FIRST_N, FUNC_LAST_N: begin
              if (stat.empty) begin
                st_nxt = STATUS_EMPTY;
              end else if (!stat.cnt_zero) begin
                cmd.walk_init = 1'b1;
                state_nxt     = S_LST_RD;
              end
            end
            default: begin
              st_nxt = stat.empty ? STATUS_EMPTY : STATUS_OK;
            end
          endcase
        end
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.pop       = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_val  = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_st   = STATUS_OK;
          state_nxt     = S_IDLE;
        end
      end
      S_DEL_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.del_step = 1'b1;
        cmd.step     = 1'b1;
        if (stat.walk_last) begin
          st_nxt    = STATUS_OK;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DEL_RD;
        end
      end
      S_LST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LST_EMIT;
      end
      S_LST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_val  = 1'b1;
          cmd.emit_last = stat.walk_last;
          cmd.emit_st   = STATUS_OK;
          cmd.step      = 1'b1;
          state_nxt     = stat.walk_last ? S_IDLE : S_LST_RD;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_st   = st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

>>> hdl/bdq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dp
// Deque datapath: ring store, head and fill count, walk counters and the
// output register.
// ----------------------------------------------------------------------------
module bdq_dp import bdq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bdq_cmd_t           cmd,
  output bdq_stat_t               stat,
  input  wire logic [2:0]         in_func,
  input  wire logic signed [31:0] in_key,
  input  wire logic [5:0]         in_count,
  input  wire logic               in_clear_all,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_value,
  output logic                    out_has_value,
  output logic                    out_last_result,
  output logic [1:0]              out_status,
  output logic [5:0]              out_occupancy
);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  logic [2:0]           func_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [5:0]           cnt_r;
  logic                 clr_r;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     i_r, j_r, n_r, start_r;
  logic [KEY_WIDTH-1:0] rd_data_r;

  logic                 out_valid_r;
  logic signed [31:0]   out_value_r;
  logic                 out_has_r, out_last_r;
  logic [1:0]           out_status_r;
  logic [5:0]           out_occ_r;

  logic [KEY_WIDTH+31:0] key_ext, val_ext;
  logic [IDX_W-1:0]      head_dec, head_inc, rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0]  wr_data;
  logic                  wr_en, keep, front, walk_last, out_free;
  logic [CNT_W-1:0]      n_calc;

  assign key_ext   = {{KEY_WIDTH{in_key[31]}}, in_key};
  assign val_ext   = {{32{rd_data_r[KEY_WIDTH-1]}}, rd_data_r};
  assign head_dec  = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - 1'b1;
  assign head_inc  = bdq_slot(head_r, CNT_W'(1));
  assign front     = (func_r == FUNC_PUSH_FRONT) || (func_r == FUNC_POP_FRONT);
  assign keep      = (rd_data_r != key_r);
  assign walk_last = ((i_r + CNT_W'(1)) == n_r);
  assign out_free  = !out_valid_r || !out_stall;

  // walk length: the fill count for a delete; for a listing, the smaller of the request and the fill count
  always_comb begin
    if (func_r == FUNC_DELETE) begin
      n_calc = count_r;
    end else if (CMP_W'(cnt_r) < CMP_W'(count_r)) begin
      n_calc = CNT_W'(cnt_r);
    end else begin
      n_calc = count_r;
    end
  end

  always_comb begin
    if (func_r == FUNC_POP_FRONT) begin
      rd_addr = head_r;
    end else if (func_r == FUNC_POP_BACK) begin
      rd_addr = bdq_slot(head_r, count_r - CNT_W'(1));
    end else begin
      rd_addr = bdq_slot(head_r, start_r + i_r);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bdq_slot(head_r, j_r);
    wr_data = rd_data_r;
    if (cmd.push) begin
      wr_en   = 1'b1;
      wr_addr = front ? head_dec : bdq_slot(head_r, count_r);
      wr_data = key_r;
    end else if (cmd.del_step) begin
      wr_en = keep;
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
      if (front) begin
        head_nxt = head_dec;
      end
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
      if (front) begin
        head_nxt = head_inc;
      end
    end else if (cmd.del_step && walk_last) begin
      count_nxt = j_r + CNT_W'(keep);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= key_ext[KEY_WIDTH-1:0];
      cnt_r  <= in_count;
      clr_r  <= in_clear_all;
    end
    if (cmd.walk_init) begin
      i_r     <= '0;
      j_r     <= '0;
      n_r     <= n_calc;
      start_r <= (func_r == FUNC_LAST_N) ? count_r - n_calc : '0;
    end else begin
      if (cmd.step) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.del_step && keep) begin
        j_r <= j_r + CNT_W'(1);
      end
    end
  end

  // output register: a new word loads only when the last one is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r  <= cmd.emit_val ? val_ext[31:0] : '0;
      out_has_r    <= cmd.emit_val;
      out_last_r   <= cmd.emit_last;
      out_status_r <= cmd.emit_st;
      out_occ_r    <= 6'(count_nxt);
    end
  end

  assign stat.func      = func_r;
  assign stat.clr       = clr_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r >= CNT_W'(CAPACITY));
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.walk_last = walk_last;
  assign stat.out_free  = out_free;

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_has_value   = out_has_r;
  assign out_last_result = out_last_r;
  assign out_status      = out_status_r;
  assign out_occupancy   = out_occ_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (count_r < CNT_W'(CAPACITY)))
    else $error("push into full store");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from empty store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result word overwritten while stalled");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (i_r < n_r))
    else $error("walk index past its length");
`endif

endmodule
`default_nettype wire

>>> hdl/bounded_deque_with_key_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_key_delete
// Bounded double-ended queue of signed keys with delete-by-key and listing.
//
// Input channel (in_valid / in_stall): one word per operation. The block
// takes a word only while idle; in_stall stays high while a word is in work.
// Result channel (out_valid / out_stall): one word per status result, or one
// per listed entry with out_last_result on the final one. Results sit in an
// output register, so a new input word is taken while a result still waits.
// Each word is loaded, then decoded: a push, clear or status-only word goes
// straight to its result; a pop reads its entry, then pops and emits it;
// delete and listing walk the store, reading one entry and then writing or
// emitting it. The walks are set by the single read port of the ring store
// with its registered read data. With no stalls the next word is taken the
// cycle after the final result loads, so words do not overlap.
// A stalled receiver holds the result and the sequencer waits before the
// next result; nothing is dropped.
// Reset (synchronous, active low) empties the deque at once: head and fill
// count go to zero; store contents are left as they are.
// ----------------------------------------------------------------------------
module bounded_deque_with_key_delete import bdq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_func,
  input  wire logic signed [31:0] in_key,
  input  wire logic [5:0]         in_count,
  input  wire logic               in_clear_all,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_value,
  output logic                    out_has_value,
  output logic                    out_last_result,
  output logic [1:0]              out_status,
  output logic [5:0]              out_occupancy
);

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bdq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_count        (in_count),
    .in_clear_all    (in_clear_all),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_has_value   (out_has_value),
    .out_last_result (out_last_result),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy)
  );

endmodule
`default_nettype wire
